/* rtl/heading_obstacle_histogram_macros.svh */
// ---------------------------------------------------------------------------
// heading_obstacle_histogram_macros: assertion helpers
// Concurrent assertion macros clocked on clk and disabled during rst_n low.
// ---------------------------------------------------------------------------
`ifndef HEADING_OBSTACLE_HISTOGRAM_MACROS_SVH
`define HEADING_OBSTACLE_HISTOGRAM_MACROS_SVH

// Check that cons holds in every cycle in which ante holds
`define HOH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond never holds
`define HOH_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

/* rtl/hoh_pkg.sv */
// ---------------------------------------------------------------------------
// hoh_pkg: shared definitions of the heading obstacle histogram
// Sizes, command codes, output codes, queue item and status types.
// ---------------------------------------------------------------------------
package hoh_pkg;

  localparam int NUM_HEADINGS = 360;
  localparam int HALF         = NUM_HEADINGS / 2;
  localparam int HEAD_W       = $clog2(NUM_HEADINGS);
  localparam int W_W          = 10;
  localparam int BEST_W       = 11;
  localparam int DIST_W       = 16;
  localparam int PEAK_W       = 7;
  localparam int PEAK_MAX     = 120;
  localparam int CNT_W        = $clog2(NUM_HEADINGS + 2 * PEAK_MAX);
  localparam int Q_DEPTH      = 2;
  localparam int Q_AW         = $clog2(Q_DEPTH);
  localparam int Q_CW         = $clog2(Q_DEPTH + 1);

  // Spread peaks by distance band
  localparam logic [PEAK_W-1:0] PEAK_FAR  = PEAK_W'(90);
  localparam logic [PEAK_W-1:0] PEAK_MID  = PEAK_W'(100);
  localparam logic [PEAK_W-1:0] PEAK_NEAR = PEAK_W'(110);
  localparam logic [PEAK_W-1:0] PEAK_HIT  = PEAK_W'(120);

  // Steering thresholds
  localparam int TURN_SPAN    = 30;
  localparam int CREEP_LIMIT  = 10;
  localparam int SLOW_LIMIT   = 20;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_WEIGHT   = 2'd0;
  localparam logic [1:0] CFG_DECAY_STEP   = 2'd1;
  localparam logic [1:0] CFG_GUARD_DIST   = 2'd2;

  localparam logic [W_W-1:0]    RST_MAX_WEIGHT = W_W'(900);
  localparam logic [W_W-1:0]    RST_DECAY_STEP = W_W'(30);
  localparam logic [DIST_W-1:0] RST_INNER      = DIST_W'(350);

  // Output codes
  localparam logic [1:0] TURN_NONE  = 2'b00;
  localparam logic [1:0] TURN_LEFT  = 2'b01;
  localparam logic [1:0] TURN_RIGHT = 2'b11;
  localparam logic [1:0] LVL_STOP   = 2'd0;
  localparam logic [1:0] LVL_CREEP  = 2'd1;
  localparam logic [1:0] LVL_SLOW   = 2'd2;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DECAY  = 2'd1,
    CMD_SELECT = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic [HEAD_W-1:0] head;
    logic [HEAD_W-1:0] cur;
    logic [PEAK_W-1:0] top;
    logic [HEAD_W-1:0] start;
  } item_t;

  typedef struct packed {
    logic init;
  } back_stat_t;

  function automatic logic [HEAD_W-1:0] head_inc(input logic [HEAD_W-1:0] h);
    return (h == HEAD_W'(NUM_HEADINGS - 1)) ? '0 : h + HEAD_W'(1);
  endfunction

  function automatic logic [HEAD_W-1:0] head_dec(input logic [HEAD_W-1:0] h);
    return (h == '0) ? HEAD_W'(NUM_HEADINGS - 1) : h - HEAD_W'(1);
  endfunction

endpackage

/* rtl/hoh_ram.sv */
// ---------------------------------------------------------------------------
// hoh_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module hoh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/hoh_front.sv */
// ---------------------------------------------------------------------------
// hoh_front: input classification
// Accepts input transactions, normalizes headings, picks the spread peak
// and the first address of the triangle, and pushes into the queue.
// ---------------------------------------------------------------------------
module hoh_front import hoh_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic [8:0]        in_obstacle_heading,
  input  logic [15:0]       in_obstacle_distance_mm,
  input  logic [8:0]        in_goal_heading,
  input  logic [8:0]        in_current_heading,
  input  logic [DIST_W-1:0] guard_mm,
  input  back_stat_t        stat,
  input  logic              q_full,
  output logic              push,
  output item_t             item
);

  localparam int S_W = HEAD_W + 2;

  function automatic logic [HEAD_W-1:0] norm_head(input logic [8:0] h);
    return (S_W'(h) >= S_W'(NUM_HEADINGS)) ? '0 : HEAD_W'(h);
  endfunction

  logic [HEAD_W-1:0] obs_h;
  logic [PEAK_W-1:0] top;
  logic [S_W-1:0]    off;
  logic [S_W-1:0]    offm;
  logic [S_W-1:0]    sum;
  cmd_t              cmd;

  assign cmd   = cmd_t'(in_cmd);
  assign obs_h = norm_head(in_obstacle_heading);

  // Choose peak from the distance band
  always_comb begin
    top = PEAK_FAR;
    if ((19'(in_obstacle_distance_mm) << 1) < 19'(guard_mm)) top = PEAK_MID;
    if ((19'(in_obstacle_distance_mm) << 2) < 19'(guard_mm)) top = PEAK_NEAR;
    if ((19'(in_obstacle_distance_mm) << 3) < 19'(guard_mm)) top = PEAK_HIT;
  end

  // First address of the triangle: heading minus (peak - 1), wrapped
  always_comb begin
    off  = S_W'(top) - S_W'(1);
    offm = (off >= S_W'(NUM_HEADINGS)) ? off - S_W'(NUM_HEADINGS) : off;
    sum  = S_W'(obs_h) + S_W'(NUM_HEADINGS) - offm;
  end

  // Build queue item
  always_comb begin
    item.cmd   = cmd;
    item.head  = (cmd == CMD_ADD) ? obs_h : norm_head(in_goal_heading);
    item.cur   = norm_head(in_current_heading);
    item.top   = top;
    item.start = (sum >= S_W'(NUM_HEADINGS)) ? HEAD_W'(sum - S_W'(NUM_HEADINGS))
                                             : HEAD_W'(sum);
  end

  assign in_stall = q_full | stat.init;
  assign push     = in_valid & ~in_stall;

endmodule

/* rtl/hoh_queue.sv */
// ---------------------------------------------------------------------------
// hoh_queue: command queue
// Short FIFO of classified transactions between front and back.
// ---------------------------------------------------------------------------
module hoh_queue import hoh_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  item_t           ent_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r;
  logic [Q_AW-1:0] rp_r;
  logic [Q_CW-1:0] cnt_r;

  function automatic logic [Q_AW-1:0] ptr_inc(input logic [Q_AW-1:0] p);
    return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + Q_AW'(1);
  endfunction

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ptr_inc(wp_r);
      if (pop)  rp_r <= ptr_inc(rp_r);
      if (push && !pop)      cnt_r <= cnt_r + Q_CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - Q_CW'(1);
    end
  end

  assign full    = (cnt_r == Q_CW'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = ent_r[rp_r];

endmodule

/* rtl/hoh_back.sv */
// ---------------------------------------------------------------------------
// hoh_back: histogram sequencer
// Walks the weight memory for add, decay, select and clear, computes the
// steering result and holds it in the output register.
// ---------------------------------------------------------------------------
module hoh_back import hoh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  input  logic [W_W-1:0]    max_weight,
  input  logic [W_W-1:0]    decay_step,
  output back_stat_t        stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_mode_active,
  output logic [8:0]        out_chosen_heading,
  output logic [10:0]       out_least_weight,
  output logic signed [1:0] out_turn_direction,
  output logic [1:0]        out_forward_level,
  output logic              out_blocked
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_ADD, S_DECAY, S_SEL, S_DRAIN, S_FIN, S_CLR, S_DONE
  } state_t;

  localparam int DT_W = HEAD_W + 2;
  localparam logic signed [DT_W-1:0] HALF_S = DT_W'(HALF);
  localparam logic signed [DT_W-1:0] N_S    = DT_W'(NUM_HEADINGS);
  localparam logic signed [DT_W-1:0] SPAN_S = DT_W'(TURN_SPAN);

  state_t            state_r;
  cmd_t              op_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [HEAD_W-1:0] addr_r;
  logic [HEAD_W-1:0] neg_r;
  logic              side_r;
  logic [PEAK_W-1:0] amt_r;
  logic              up_r;
  logic [PEAK_W-1:0] top_r;
  logic [HEAD_W-1:0] cur_r;
  logic              rd_vld_r;
  logic [HEAD_W-1:0] rd_addr_r;
  logic [PEAK_W-1:0] rd_amt_r;
  logic [BEST_W-1:0] best_r;
  logic [HEAD_W-1:0] bh_r;
  logic              nz_r;
  logic              avoid_r;

  logic              res_mode_r;
  logic [HEAD_W-1:0] res_head_r;
  logic [BEST_W-1:0] res_least_r;
  logic [1:0]        res_turn_r;
  logic [1:0]        res_lvl_r;
  logic              res_blk_r;

  logic              out_valid_r;
  logic              out_mode_r;
  logic [8:0]        out_head_r;
  logic [10:0]       out_least_r;
  logic [1:0]        out_turn_r;
  logic [1:0]        out_lvl_r;
  logic              out_blk_r;

  logic              issue;
  logic              clearing;
  logic [HEAD_W-1:0] raddr;
  logic [W_W-1:0]    rdata;
  logic              we;
  logic [HEAD_W-1:0] waddr;
  logic [W_W-1:0]    wdata;
  logic [W_W-1:0]    wval;
  logic [BEST_W-1:0] sat_sum;
  logic              sel_hit;

  logic signed [DT_W-1:0] dt0;
  logic signed [DT_W-1:0] dt;
  logic [1:0]             st_turn;
  logic [1:0]             st_lvl;

  // Read side of the walk
  assign issue    = (state_r == S_ADD) || (state_r == S_DECAY) || (state_r == S_SEL);
  assign clearing = (state_r == S_INIT) || (state_r == S_CLR);
  assign raddr    = (state_r == S_SEL && side_r) ? neg_r : addr_r;

  // Update the entry that the previous read returned
  always_comb begin
    sat_sum = BEST_W'(rdata) + BEST_W'(rd_amt_r);
    wval    = '0;
    case (op_r)
      CMD_ADD:   wval = (sat_sum > BEST_W'(max_weight)) ? max_weight : W_W'(sat_sum);
      CMD_DECAY: wval = (rdata > decay_step) ? rdata - decay_step : '0;
      default:   wval = '0;
    endcase
    sel_hit = (BEST_W'(rdata) < best_r);
  end

  assign we    = clearing || (rd_vld_r && (op_r == CMD_ADD || op_r == CMD_DECAY));
  assign waddr = clearing ? addr_r : rd_addr_r;
  assign wdata = clearing ? '0 : wval;

  hoh_ram #(.WIDTH(W_W), .DEPTH(NUM_HEADINGS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Steering toward the chosen heading
  always_comb begin
    dt0 = $signed({2'b00, bh_r}) - $signed({2'b00, cur_r});
    if (dt0 > HALF_S)       dt = dt0 - N_S;
    else if (dt0 < -HALF_S) dt = dt0 + N_S;
    else                    dt = dt0;
    if (dt > 0) begin
      st_turn = TURN_LEFT;
      st_lvl  = (best_r < BEST_W'(CREEP_LIMIT) && dt < SPAN_S) ? LVL_CREEP : LVL_STOP;
    end else if (dt < 0) begin
      st_turn = TURN_RIGHT;
      st_lvl  = (best_r < BEST_W'(CREEP_LIMIT) && dt > -SPAN_S) ? LVL_CREEP : LVL_STOP;
    end else begin
      st_turn = TURN_NONE;
      st_lvl  = (best_r < BEST_W'(SLOW_LIMIT)) ? LVL_SLOW : LVL_STOP;
    end
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign stat.init = (state_r == S_INIT);

  // Sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      op_r        <= CMD_CLEAR;
      addr_r      <= '0;
      cnt_r       <= CNT_W'(NUM_HEADINGS);
      rd_vld_r    <= 1'b0;
      avoid_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r  <= issue;
      rd_addr_r <= raddr;
      rd_amt_r  <= amt_r;

      // Fold returned data into running status
      if (rd_vld_r) begin
        if (op_r == CMD_DECAY && wval != '0) nz_r <= 1'b1;
        if (op_r == CMD_SELECT && sel_hit) begin
          best_r <= BEST_W'(rdata);
          bh_r   <= rd_addr_r;
        end
      end

      // Load a finished result, or drop the one taken
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_INIT, S_CLR: begin
          addr_r <= head_inc(addr_r);
          cnt_r  <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            if (state_r == S_INIT) begin
              state_r <= S_IDLE;
            end else begin
              avoid_r    <= 1'b0;
              res_mode_r <= 1'b0;
              state_r    <= S_DONE;
            end
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            op_r        <= q_item.cmd;
            cur_r       <= q_item.cur;
            top_r       <= q_item.top;
            res_head_r  <= '0;
            res_least_r <= '0;
            res_turn_r  <= TURN_NONE;
            res_lvl_r   <= LVL_STOP;
            res_blk_r   <= 1'b0;
            res_mode_r  <= avoid_r;
            case (q_item.cmd)
              CMD_ADD: begin
                addr_r  <= q_item.start;
                cnt_r   <= CNT_W'({q_item.top, 1'b0}) - CNT_W'(1);
                amt_r   <= PEAK_W'(1);
                up_r    <= 1'b1;
                state_r <= S_ADD;
              end
              CMD_DECAY: begin
                addr_r  <= '0;
                cnt_r   <= CNT_W'(NUM_HEADINGS);
                nz_r    <= 1'b0;
                state_r <= avoid_r ? S_DECAY : S_DONE;
              end
              CMD_SELECT: begin
                addr_r  <= head_inc(q_item.head);
                neg_r   <= q_item.head;
                side_r  <= 1'b1;
                cnt_r   <= CNT_W'(2 * HALF - 1);
                best_r  <= BEST_W'(max_weight) + BEST_W'(1);
                bh_r    <= '0;
                state_r <= S_SEL;
              end
              default: begin
                addr_r  <= '0;
                cnt_r   <= CNT_W'(NUM_HEADINGS);
                state_r <= S_CLR;
              end
            endcase
          end
        end
        S_ADD, S_DECAY, S_SEL: begin
          cnt_r <= cnt_r - CNT_W'(1);
          if (state_r == S_SEL) begin
            if (side_r) neg_r <= head_dec(neg_r);
            else        addr_r <= head_inc(addr_r);
            side_r <= ~side_r;
          end else begin
            addr_r <= head_inc(addr_r);
          end
          // Triangle amount rises to the peak, then falls
          if (up_r && amt_r == top_r) begin
            up_r  <= 1'b0;
            amt_r <= amt_r - PEAK_W'(1);
          end else if (up_r) begin
            amt_r <= amt_r + PEAK_W'(1);
          end else begin
            amt_r <= amt_r - PEAK_W'(1);
          end
          if (cnt_r == CNT_W'(1)) state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          case (op_r)
            CMD_ADD: begin
              avoid_r    <= 1'b1;
              res_mode_r <= 1'b1;
              state_r    <= S_DONE;
            end
            CMD_DECAY: begin
              avoid_r    <= nz_r;
              res_mode_r <= nz_r;
              state_r    <= S_DONE;
            end
            default: begin
              res_least_r <= best_r;
              if (best_r == BEST_W'(max_weight)) begin
                res_blk_r <= 1'b1;
                addr_r    <= '0;
                cnt_r     <= CNT_W'(NUM_HEADINGS);
                state_r   <= S_CLR;
              end else begin
                res_head_r <= bh_r;
                res_turn_r <= st_turn;
                res_lvl_r  <= st_lvl;
                state_r    <= S_DONE;
              end
            end
          endcase
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_mode_r  <= res_mode_r;
            out_head_r  <= 9'(res_head_r);
            out_least_r <= res_least_r;
            out_turn_r  <= res_turn_r;
            out_lvl_r   <= res_lvl_r;
            out_blk_r   <= res_blk_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode_active    = out_mode_r;
  assign out_chosen_heading = out_head_r;
  assign out_least_weight   = out_least_r;
  assign out_turn_direction = $signed(out_turn_r);
  assign out_forward_level  = out_lvl_r;
  assign out_blocked        = out_blk_r;

endmodule

/* rtl/heading_obstacle_histogram.sv */
// ---------------------------------------------------------------------------
// heading_obstacle_histogram: polar obstacle histogram with steering
// Per-degree weight store with add, decay, select and clear commands.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command transaction;
//   every transaction yields exactly one result transaction on the output
//   channel (out_valid / out_stall). Configuration writes go through
//   cfg_we / cfg_index / cfg_data; the user must make them only while the
//   block is idle, which the block does not enforce. Transactions are
//   classified on entry and wait in a two-entry queue, so the input keeps
//   accepting until the queue is full while a result waits for the
//   receiver. The weight memory is walked one entry per cycle: add 2*peak-1
//   entries, decay 360 (none if inactive), select 359 from the goal out,
//   clear 360; a blocked select adds a clearing pass. Back-to-back results
//   come one per walk, via the queue and the output register. After reset
//   a clearing pass over all 360 entries zeroes the memory; in_stall stays
//   high through it. A stalled receiver holds the result register, and the
//   back end waits with the next result until it is taken.
// ---------------------------------------------------------------------------
`include "heading_obstacle_histogram_macros.svh"

module heading_obstacle_histogram import hoh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_cmd,
  input  logic [8:0]        in_obstacle_heading,
  input  logic [15:0]       in_obstacle_distance_mm,
  input  logic [8:0]        in_goal_heading,
  input  logic [8:0]        in_current_heading,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_mode_active,
  output logic [8:0]        out_chosen_heading,
  output logic [10:0]       out_least_weight,
  output logic signed [1:0] out_turn_direction,
  output logic [1:0]        out_forward_level,
  output logic              out_blocked
);

  logic [W_W-1:0]    max_weight_r;
  logic [W_W-1:0]    decay_step_r;
  logic [DIST_W-1:0] guard_mm_r;

  back_stat_t stat;
  logic       q_full;
  logic       push;
  item_t      push_item;
  logic       pop;
  logic       q_valid;
  item_t      q_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_weight_r <= RST_MAX_WEIGHT;
      decay_step_r <= RST_DECAY_STEP;
      guard_mm_r   <= RST_INNER;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_WEIGHT: max_weight_r <= cfg_data[W_W-1:0];
        CFG_DECAY_STEP: decay_step_r <= cfg_data[W_W-1:0];
        CFG_GUARD_DIST: guard_mm_r   <= cfg_data;
        default:        ;
      endcase
    end
  end

  hoh_front u_front (
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_cmd                  (in_cmd),
    .in_obstacle_heading     (in_obstacle_heading),
    .in_obstacle_distance_mm (in_obstacle_distance_mm),
    .in_goal_heading         (in_goal_heading),
    .in_current_heading      (in_current_heading),
    .guard_mm                (guard_mm_r),
    .stat                    (stat),
    .q_full                  (q_full),
    .push                    (push),
    .item                    (push_item)
  );

  hoh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  hoh_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (pop),
    .max_weight         (max_weight_r),
    .decay_step         (decay_step_r),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mode_active    (out_mode_active),
    .out_chosen_heading (out_chosen_heading),
    .out_least_weight   (out_least_weight),
    .out_turn_direction (out_turn_direction),
    .out_forward_level  (out_forward_level),
    .out_blocked        (out_blocked)
  );

  // Assertions
  `HOH_ASSERT_NEVER(a_no_push_in_init, push && stat.init, "transaction taken during clearing pass")
  `HOH_ASSERT_NEVER(a_no_overflow, push && q_full && !pop, "queue overflow")
  `HOH_ASSERT_IMPL(a_blocked_clean, out_valid && out_blocked, (out_chosen_heading == 9'd0) && !out_mode_active, "blocked result not cleared")
  `HOH_ASSERT_IMPL(a_slow_straight, out_valid && (out_forward_level == LVL_SLOW), out_turn_direction == 2'sd0, "slow advance while turning")

endmodule
